// ===== rtl/enm_pkg.sv =====
`timescale 1ns / 1ps

package enm_pkg;

    // image geometry
    localparam int IMAGE_WIDTH  = 256;
    localparam int IMAGE_HEIGHT = 256;
    localparam int COL_W        = $clog2(IMAGE_WIDTH);
    localparam int ROW_W        = $clog2(IMAGE_HEIGHT);

    // field widths
    localparam int GRAD_W   = 24;
    localparam int MAG_W    = 16;
    localparam int BORDER_W = 7;
    localparam int POS_W    = 8;

    // position compare width, wide enough for count plus border band
    localparam int MAX_CNT_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W     = ((MAX_CNT_W > BORDER_W) ? MAX_CNT_W : BORDER_W) + 2;

    // slope thresholds as q16 tangents of 22.5 and 67.5 degrees
    localparam int FRAC_BITS  = 16;
    localparam int TAN_LO_Q16 = 27145;
    localparam int TAN_HI_Q16 = 158219;
    localparam int TAN_LO_W   = 15;
    localparam int TAN_HI_W   = 18;
    localparam int LHS_W      = GRAD_W + 1 + FRAC_BITS;
    localparam int LO_W       = GRAD_W + TAN_LO_W;
    localparam int HI_W       = GRAD_W + TAN_HI_W;
    localparam int SLOPE_W    = HI_W + 1;

    localparam logic [BORDER_W-1:0] BORDER_RESET = BORDER_W'(3);

    typedef enum logic [1:0] {
        BIN_HORZ     = 2'd0,
        BIN_DIAG_POS = 2'd1,
        BIN_DIAG_NEG = 2'd2,
        BIN_VERT     = 2'd3
    } t_dir_bin;

    typedef struct packed {
        logic [MAG_W-1:0] older;
        logic [MAG_W-1:0] newer;
        t_dir_bin         bin;
    } t_line_entry;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        t_line_entry      data;
    } t_line_wr;

endpackage

// ===== rtl/enm_dir_unit.sv =====
`timescale 1ns / 1ps

module enm_dir_unit (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [enm_pkg::GRAD_W-1:0] i_grad_x,
    input  logic signed [enm_pkg::GRAD_W-1:0] i_grad_y,
    output enm_pkg::t_dir_bin                 o_bin
);
    import enm_pkg::*;

    logic                    neg;
    logic [GRAD_W-1:0]       ax;
    logic signed [GRAD_W:0]  gy_x;
    logic signed [GRAD_W:0]  sy;

    logic signed [LHS_W-1:0] r_lhs;
    logic [LO_W-1:0]         r_lo;
    logic [HI_W-1:0]         r_hi;
    logic                    r_gx_zero;
    logic                    r_gy_zero;

    logic signed [SLOPE_W-1:0] lhs_x;
    logic signed [SLOPE_W-1:0] lo_x;
    logic signed [SLOPE_W-1:0] hi_x;

    // fold into the right half plane so only the sign of gy matters
    assign neg  = i_grad_x[GRAD_W-1];
    assign ax   = neg ? GRAD_W'(-i_grad_x) : i_grad_x;
    assign gy_x = {i_grad_y[GRAD_W-1], i_grad_y};
    assign sy   = neg ? -gy_x : gy_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lhs     <= {sy, {FRAC_BITS{1'b0}}};
            r_lo      <= LO_W'(ax) * LO_W'(TAN_LO_Q16);
            r_hi      <= HI_W'(ax) * HI_W'(TAN_HI_Q16);
            r_gx_zero <= (i_grad_x == '0);
            r_gy_zero <= (i_grad_y == '0);
        end
    end

    assign lhs_x = SLOPE_W'(r_lhs);
    assign lo_x  = $signed({{(SLOPE_W-LO_W){1'b0}}, r_lo});
    assign hi_x  = $signed({{(SLOPE_W-HI_W){1'b0}}, r_hi});

    always_comb begin
        if (r_gx_zero) begin
            o_bin = r_gy_zero ? BIN_HORZ : BIN_VERT;
        end else if (lhs_x <= lo_x && lhs_x > -lo_x) begin
            o_bin = BIN_HORZ;
        end else if (lhs_x <= hi_x && lhs_x > lo_x) begin
            o_bin = BIN_DIAG_POS;
        end else if (lhs_x <= -lo_x && lhs_x > -hi_x) begin
            o_bin = BIN_DIAG_NEG;
        end else begin
            o_bin = BIN_VERT;
        end
    end

endmodule

// ===== rtl/enm_line_store.sv =====
`timescale 1ns / 1ps

module enm_line_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [enm_pkg::COL_W-1:0] i_rd_addr,
    input  enm_pkg::t_line_wr         i_wr,
    output enm_pkg::t_line_entry      o_rd_data
);
    import enm_pkg::*;

    t_line_entry r_mem [IMAGE_WIDTH];
    t_line_entry r_rd_data;
    t_line_entry r_byp_data;
    logic        r_byp_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // read and write of one column at one edge: take the new entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_byp_hit <= i_wr.en && (i_wr.addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_data <= i_wr.data;
        end
    end

    assign o_rd_data = r_byp_hit ? r_byp_data : r_rd_data;

endmodule

// ===== rtl/edge_nonmax_suppression.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: grad_x, grad_y, magnitude; tuser: frame_start
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: row, column; tuser: is_edge
// cfg       in   i_cfg_valid/o_cfg_ready      border_width
//
// one pixel per clock while the output is not stalled; a result passes the compare stage, then the output register
// the line store read and the slope products set the two-stage depth
// a pixel that lands on the column just written gets the written entry by bypass
// sync active-low reset clears counters, window, border band (3); line store is not cleared
// a stalled output holds the compare stage, which in turn holds the input

module edge_nonmax_suppression (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // grad_x[23:0], grad_y[47:24], magnitude[63:48]
    input  logic        s_axis_tuser,   // frame_start[0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // row[7:0], column[15:8]
    output logic        m_axis_tuser,   // is_edge[0]
    // border band register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);
    import enm_pkg::*;

    // input side
    logic                    s_accept;
    logic signed [GRAD_W-1:0] in_grad_x;
    logic signed [GRAD_W-1:0] in_grad_y;
    logic [MAG_W-1:0]        in_mag;
    logic [ROW_W-1:0]        s0_row;
    logic [COL_W-1:0]        s0_col;
    logic [ROW_W-1:0]        r_row,  n_row;
    logic [COL_W-1:0]        r_col,  n_col;

    // compare stage
    logic                    r_s1_valid;
    logic [ROW_W-1:0]        r_s1_row;
    logic [COL_W-1:0]        r_s1_col;
    logic [MAG_W-1:0]        r_s1_mag;
    logic                    s1_fire;
    logic                    out_free;

    logic [MAG_W-1:0]        r_win [6];
    t_dir_bin                r_bin_dly;
    t_dir_bin                new_bin;
    t_line_entry             rd_entry;
    t_line_wr                wr_port;

    logic [MAG_W-1:0]        up_c;
    logic [MAG_W-1:0]        mid_c;
    logic [MAG_W-1:0]        nb_a;
    logic [MAG_W-1:0]        nb_b;
    logic                    is_edge;

    // border check
    logic [BORDER_W-1:0]     r_border;
    logic [CMP_W-1:0]        bw_x;
    logic [CMP_W-1:0]        row_x;
    logic [CMP_W-1:0]        col_x;
    logic [CMP_W-1:0]        row_m1;
    logic [CMP_W-1:0]        col_m1;
    logic                    interior;

    // output register
    logic                    r_out_valid;
    logic [POS_W-1:0]        r_out_row;
    logic [POS_W-1:0]        r_out_col;
    logic                    r_out_edge;

    assign in_grad_x = s_axis_tdata[23:0];
    assign in_grad_y = s_axis_tdata[47:24];
    assign in_mag    = s_axis_tdata[63:48];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // raster position, frame_start restarts at the origin
    assign s0_row = s_axis_tuser ? '0 : r_row;
    assign s0_col = s_axis_tuser ? '0 : r_col;

    always_comb begin
        n_row = s0_row;
        n_col = s0_col + COL_W'(1);
        if (s0_col == COL_W'(IMAGE_WIDTH - 1)) begin
            n_col = '0;
            if (s0_row == ROW_W'(IMAGE_HEIGHT - 1)) begin
                n_row = '0;
            end else begin
                n_row = s0_row + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_row <= s0_row;
            r_s1_col <= s0_col;
            r_s1_mag <= in_mag;
        end
    end

    // slope products registered with the pixel, bin decided in the compare stage
    enm_dir_unit u_dir (
        .i_clk    (i_clk),
        .i_en     (s_accept),
        .i_grad_x (in_grad_x),
        .i_grad_y (in_grad_y),
        .o_bin    (new_bin)
    );

    // line store: older row, newer row and bin of the row above, one entry per column
    assign wr_port.en          = s1_fire;
    assign wr_port.addr        = r_s1_col;
    assign wr_port.data.older  = mid_c;
    assign wr_port.data.newer  = r_s1_mag;
    assign wr_port.data.bin    = new_bin;

    enm_line_store u_lines (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_accept),
        .i_rd_addr (s0_col),
        .i_wr      (wr_port),
        .o_rd_data (rd_entry)
    );

    assign up_c  = rd_entry.older;
    assign mid_c = rd_entry.newer;

    // window: [0],[1] two rows up, [2],[3] one row up, [4],[5] this row; center is [3]
    always_comb begin
        case (r_bin_dly)
            BIN_HORZ: begin
                nb_a = r_win[2];
                nb_b = mid_c;
            end
            BIN_DIAG_POS: begin
                nb_a = r_win[0];
                nb_b = r_s1_mag;
            end
            BIN_DIAG_NEG: begin
                nb_a = r_win[4];
                nb_b = up_c;
            end
            default: begin
                nb_a = r_win[1];
                nb_b = r_win[5];
            end
        endcase
    end

    assign is_edge = (r_win[3] > nb_a) && (r_win[3] > nb_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
            r_bin_dly <= BIN_HORZ;
        end else if (s1_fire) begin
            r_win[0]  <= r_win[1];
            r_win[1]  <= up_c;
            r_win[2]  <= r_win[3];
            r_win[3]  <= mid_c;
            r_win[4]  <= r_win[5];
            r_win[5]  <= r_s1_mag;
            r_bin_dly <= rd_entry.bin;
        end
    end

    // center sits one row up and one column left; a zero band acts as one
    assign bw_x   = (r_border == '0) ? CMP_W'(1) : CMP_W'(r_border);
    assign row_x  = CMP_W'(r_s1_row);
    assign col_x  = CMP_W'(r_s1_col);
    assign row_m1 = row_x - CMP_W'(1);
    assign col_m1 = col_x - CMP_W'(1);
    assign interior = (row_x >= bw_x + CMP_W'(1)) &&
                      (row_x + bw_x <= CMP_W'(IMAGE_HEIGHT)) &&
                      (col_x >= bw_x + CMP_W'(1)) &&
                      (col_x + bw_x <= CMP_W'(IMAGE_WIDTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= interior;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_row  <= row_m1[POS_W-1:0];
            r_out_col  <= col_m1[POS_W-1:0];
            r_out_edge <= is_edge;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_col, r_out_row};
    assign m_axis_tuser  = r_out_edge;

    // border band register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border <= BORDER_RESET;
        end else if (i_cfg_valid) begin
            r_border <= i_cfg_data;
        end
    end

`ifndef SYNTHESIS
    // a held compare stage keeps its pixel
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_fire |=> r_s1_valid)
        else $error("compare stage lost a pixel");

    // no new pixel while the compare stage is held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_fire |-> !s_axis_tready)
        else $error("input taken over a held pixel");

    // column counter stays inside the line
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= COL_W'(IMAGE_WIDTH - 1)) &&
        (!r_s1_valid || (r_s1_col <= COL_W'(IMAGE_WIDTH - 1))))
        else $error("column count out of range");

    // a result only leaves the compare stage when the output can take it
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !s1_fire)
        else $error("output register overwritten");
`endif

endmodule

// ===== test/edge_nonmax_suppression_tb.sv =====
`timescale 1ns / 1ps

module edge_nonmax_suppression_tb;

    import enm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 4;      // pipeline is two deep, keep some margin
    localparam int LONG_HOLD     = 300;
    localparam int CRAFT_COUNT   = 21;
    localparam int CRAFT_FIRST   = 3 * IMAGE_WIDTH + 4;   // row 3, column 4
    localparam int HOLD_AT_ITEM  = 4 * IMAGE_WIDTH + 16;  // results flowing by then
    localparam int FIRST_RUN     = 4 * IMAGE_WIDTH + 40;  // covers the hand-picked centers of row 3
    localparam int SHORT_RUN     = 2 * IMAGE_WIDTH + 40;  // reaches row 2

    typedef struct {
        logic                      frame_start;
        logic signed [GRAD_W-1:0]  grad_x;
        logic signed [GRAD_W-1:0]  grad_y;
        logic        [MAG_W-1:0]   magnitude;
    } t_pixel;

    typedef struct {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic             is_edge;
    } t_nms_result;

    // tracks line stores, window and counters, and queues the results they imply
    class edge_scoreboard;
        logic [MAG_W-1:0]    older_line [IMAGE_WIDTH];
        logic [MAG_W-1:0]    newer_line [IMAGE_WIDTH];
        t_dir_bin            bin_line [IMAGE_WIDTH];
        logic [MAG_W-1:0]    win [6];
        int                  row_cnt;
        int                  col_cnt;
        t_dir_bin            center_bin;
        logic [BORDER_W-1:0] border;
        t_nms_result         expected_edges [$];
        int                  mismatches;

        function new();
            for (int i = 0; i < IMAGE_WIDTH; i++) begin
                older_line[i] = '0;
                newer_line[i] = '0;
                bin_line[i]   = BIN_HORZ;
            end
            for (int i = 0; i < 6; i++) win[i] = '0;
            row_cnt    = 0;
            col_cnt    = 0;
            center_bin = BIN_HORZ;
            border     = BORDER_RESET;
            mismatches = 0;
        endfunction

        function void set_border(logic [BORDER_W-1:0] value);
            border = value;
        endfunction

        // slope bin by cross-multiplication; a zero gx counts as a tiny positive value
        function t_dir_bin slope_bin(logic signed [GRAD_W-1:0] gx_in,
                                     logic signed [GRAD_W-1:0] gy_in);
            longint gx, gy, lhs, lo, hi;
            gx = gx_in;
            gy = gy_in;
            if (gx == 0) return (gy == 0) ? BIN_HORZ : BIN_VERT;
            if (gx < 0) begin
                gx = -gx;
                gy = -gy;
            end
            lhs = gy * (longint'(1) << FRAC_BITS);
            lo  = longint'(TAN_LO_Q16) * gx;
            hi  = longint'(TAN_HI_Q16) * gx;
            if (lhs <= lo && lhs > -lo) return BIN_HORZ;
            if (lhs <= hi && lhs > lo) return BIN_DIAG_POS;
            if (lhs <= -lo && lhs > -hi) return BIN_DIAG_NEG;
            return BIN_VERT;
        endfunction

        function void take_pixel(t_pixel p);
            int               r, c, bw;
            logic [MAG_W-1:0] up_mag, mid_mag, ctr, side_a, side_b;
            t_dir_bin         fresh_bin;
            t_nms_result      res;
            if (p.frame_start) begin
                row_cnt = 0;
                col_cnt = 0;
            end
            r         = row_cnt;
            c         = col_cnt;
            fresh_bin = slope_bin(p.grad_x, p.grad_y);
            up_mag    = older_line[c];
            mid_mag   = newer_line[c];
            ctr       = win[3];
            case (center_bin)
                BIN_HORZ: begin
                    side_a = win[2];
                    side_b = mid_mag;
                end
                BIN_DIAG_POS: begin
                    side_a = win[0];
                    side_b = p.magnitude;
                end
                BIN_DIAG_NEG: begin
                    side_a = win[4];
                    side_b = up_mag;
                end
                default: begin
                    side_a = win[1];
                    side_b = win[5];
                end
            endcase
            bw = (border == 0) ? 1 : int'(border);
            if (r >= 1 && c >= 1 && r - 1 >= bw && r - 1 <= IMAGE_HEIGHT - 1 - bw &&
                c - 1 >= bw && c - 1 <= IMAGE_WIDTH - 1 - bw) begin
                res.row     = POS_W'(r - 1);
                res.column  = POS_W'(c - 1);
                res.is_edge = (ctr > side_a) && (ctr > side_b);
                expected_edges.push_back(res);
            end
            // window slides one column; line stores move down one row
            win[0] = win[1];  win[1] = up_mag;
            win[2] = win[3];  win[3] = mid_mag;
            win[4] = win[5];  win[5] = p.magnitude;
            center_bin    = bin_line[c];
            bin_line[c]   = fresh_bin;
            older_line[c] = mid_mag;
            newer_line[c] = p.magnitude;
            c++;
            if (c >= IMAGE_WIDTH) begin
                c = 0;
                r++;
                if (r >= IMAGE_HEIGHT) r = 0;
            end
            row_cnt = r;
            col_cnt = c;
        endfunction

        function void check_result(t_nms_result got);
            t_nms_result want;
            if (expected_edges.size() == 0) begin
                $error("result with none expected: row %0d column %0d is_edge %0d",
                       got.row, got.column, got.is_edge);
                mismatches++;
                return;
            end
            want = expected_edges.pop_front();
            if (got.row !== want.row) begin
                $error("row: expected %0d, actual %0d", want.row, got.row);
                mismatches++;
            end
            if (got.column !== want.column) begin
                $error("column: expected %0d, actual %0d", want.column, got.column);
                mismatches++;
            end
            if (got.is_edge !== want.is_edge) begin
                $error("is_edge: expected %0d, actual %0d (row %0d column %0d)",
                       want.is_edge, got.is_edge, want.row, want.column);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_edges.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;    // grad_x[23:0], grad_y[47:24], magnitude[63:48]
    logic        s_axis_tuser;    // frame_start[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // row[7:0], column[15:8]
    logic        m_axis_tuser;    // is_edge[0]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;

    edge_scoreboard sb;
    int             cycle_count = 0;
    int unsigned    results_seen = 0;
    int unsigned    burst_left = 0;
    bit             hold_request = 1'b0;
    bit             mag_narrow = 1'b0;   // tiny magnitudes so neighbors tie often
    t_nms_result    seen_result;
    t_pixel         seen_pixel;

    edge_nonmax_suppression dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #(CLK_HALF);
        i_clk = 1'b1;
        #(CLK_HALF);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // sample both channels and the register write at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_result.row     = m_axis_tdata[7:0];
                seen_result.column  = m_axis_tdata[15:8];
                seen_result.is_edge = m_axis_tuser;
                sb.check_result(seen_result);
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen_pixel.grad_x      = s_axis_tdata[23:0];
                seen_pixel.grad_y      = s_axis_tdata[47:24];
                seen_pixel.magnitude   = s_axis_tdata[63:48];
                seen_pixel.frame_start = s_axis_tuser;
                sb.take_pixel(seen_pixel);
            end
            if (i_cfg_valid && o_cfg_ready) sb.set_border(i_cfg_data);
        end
    end

    // receiver: phases of always ready, mostly ready and mostly stalled, plus one
    // long hold-off on request so the block backs up into its input
    initial begin
        int unsigned hold_left;
        int unsigned phase_left;
        int unsigned rx_mode;
        hold_left  = 0;
        phase_left = 0;
        rx_mode    = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    rx_mode    = $urandom_range(0, 2);
                    phase_left = $urandom_range(8, 150);
                end
                phase_left--;
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic t_pixel random_pixel();
        t_pixel p;
        longint base, slope;
        p.frame_start = 1'b0;
        case ($urandom_range(0, 9))
            5: begin
                p.grad_x = GRAD_W'(int'($urandom_range(0, 8)) - 4);
                p.grad_y = GRAD_W'(int'($urandom_range(0, 8)) - 4);
            end
            6: begin
                // zero gx with a gy of either sign or zero
                p.grad_x = '0;
                case ($urandom_range(0, 2))
                    0:       p.grad_y = '0;
                    1:       p.grad_y = GRAD_W'(int'($urandom_range(0, 8)) - 4);
                    default: p.grad_y = GRAD_W'($urandom);
                endcase
            end
            7: begin
                // slope right around one of the two bin boundaries
                if ($urandom_range(0, 1))
                    base = longint'($urandom_range(1, 4)) << FRAC_BITS;
                else
                    base = longint'($urandom_range(1, 2000000));
                slope = ((($urandom_range(0, 1)) ? longint'(TAN_HI_Q16) : longint'(TAN_LO_Q16))
                         * base) >>> FRAC_BITS;
                slope = slope + int'($urandom_range(0, 2)) - 1;
                p.grad_x = GRAD_W'(($urandom_range(0, 1)) ? base : -base);
                p.grad_y = GRAD_W'(($urandom_range(0, 1)) ? slope : -slope);
            end
            8, 9: begin
                p.grad_x = GRAD_W'(int'($urandom_range(0, 2000)) - 1000);
                p.grad_y = GRAD_W'(int'($urandom_range(0, 2000)) - 1000);
            end
            default: begin
                p.grad_x = GRAD_W'($urandom);
                p.grad_y = GRAD_W'($urandom);
            end
        endcase
        if (mag_narrow)
            p.magnitude = MAG_W'($urandom_range(0, 3));
        else
            case ($urandom_range(0, 15))
                0:       p.magnitude = '0;
                1:       p.magnitude = '1;
                default: p.magnitude = MAG_W'($urandom);
            endcase
        return p;
    endfunction

    // hand-picked gradients: zero gx, exact bin boundaries, full-scale values
    function automatic void craft_pixel(input int unsigned k, inout t_pixel p);
        longint gx, gy;
        case (k)
            0:  begin gx = 0;         gy = 0;         end
            1:  begin gx = 0;         gy = 5;         end
            2:  begin gx = 0;         gy = -5;        end
            3:  begin gx = 65536;     gy = 27145;     end
            4:  begin gx = 65536;     gy = 27146;     end
            5:  begin gx = 65536;     gy = 158219;    end
            6:  begin gx = 65536;     gy = 158220;    end
            7:  begin gx = 65536;     gy = -27145;    end
            8:  begin gx = 65536;     gy = -27144;    end
            9:  begin gx = 65536;     gy = -158219;   end
            10: begin gx = 65536;     gy = -158218;   end
            11: begin gx = -65536;    gy = -27145;    end
            12: begin gx = -65536;    gy = 27145;     end
            13: begin gx = 8388607;   gy = -8388608;  end
            14: begin gx = -8388608;  gy = 8388607;   end
            15: begin gx = -8388608;  gy = -8388608;  end
            16: begin gx = 8388607;   gy = 8388607;   end
            17: begin gx = 1;         gy = 0;         end
            18: begin gx = -1;        gy = 0;         end
            19: begin gx = 0;         gy = -8388608;  end
            default: begin gx = 0;    gy = 8388607;   end
        endcase
        p.grad_x = GRAD_W'(gx);
        p.grad_y = GRAD_W'(gy);
        if (k % 3 == 0) p.magnitude = '1;
        else if (k % 3 == 1) p.magnitude = '0;
    endfunction

    // one item, preceded now and then by a gap between bursts
    task automatic send_pixel(input t_pixel p);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 64);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
            gap = 0;
        end
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.magnitude, p.grad_y, p.grad_x};
        s_axis_tuser  <= p.frame_start;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic send_run(input int unsigned count, input bit restart, input bit crafted);
        t_pixel      p;
        int unsigned k;
        for (int unsigned i = 0; i < count; i++) begin
            p = random_pixel();
            p.frame_start = restart && (i == 0);
            if (crafted && i >= CRAFT_FIRST && i < CRAFT_FIRST + CRAFT_COUNT) begin
                k = i - CRAFT_FIRST;
                craft_pixel(k, p);
            end
            if (crafted && i == HOLD_AT_ITEM) hold_request = 1'b1;
            send_pixel(p);
        end
    endtask

    // stop offering pixels and wait until every predicted result is back
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_border(input logic [BORDER_W-1:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned         frames;
        int unsigned         items;
        int unsigned         len;
        int unsigned         base_results;
        logic [BORDER_W-1:0] bw_pick;
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // four rows and a bit at the reset border band; row 3 has the hand-picked centers
        send_run(FIRST_RUN, 1'b1, 1'b1);

        // widest band reports nothing here, a zero band acts as one
        write_border(BORDER_W'(127));
        send_run(SHORT_RUN, 1'b1, 1'b0);
        write_border(BORDER_W'(0));
        send_run(SHORT_RUN, 1'b1, 1'b0);

        // random frames: mostly long enough to reach interior rows, some cut short
        frames       = 0;
        items        = 0;
        base_results = results_seen;
        while (frames < 2 || items < 400 || results_seen - base_results < 48) begin
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       bw_pick = BORDER_W'(127);
                    1:       bw_pick = BORDER_W'(0);
                    2:       bw_pick = BORDER_W'($urandom_range(1, 127));
                    default: bw_pick = BORDER_W'($urandom_range(1, 6));
                endcase
                write_border(bw_pick);
            end
            mag_narrow = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
                len = 2 * IMAGE_WIDTH + $urandom_range(10, 600);
            else
                len = $urandom_range(1, 400);
            send_run(len, 1'b1, 1'b0);
            items += len;
            frames++;
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
